// ===== rtl/cdrt_pkg.sv =====
// cdrt_pkg: shared types and constants for the command dedup and report throttle block
// item and result layouts, opcode, kind and action codes, configuration indexes
// no dependencies
package cdrt_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 1'd1;

  localparam logic [CFG_DATA_W-1:0] HEARTBEAT_RESET = 31'd10000;
  localparam logic [CFG_DATA_W-1:0] MIN_GAP_RESET   = 31'd250;

  localparam logic [1:0] OP_COMMAND = 2'd0;
  localparam logic [1:0] OP_POLL    = 2'd1;
  localparam logic [1:0] OP_FORCE   = 2'd2;

  localparam logic [7:0] KIND_THEME      = 8'd0;
  localparam logic [7:0] KIND_SCREEN     = 8'd1;
  localparam logic [7:0] KIND_BRIGHTNESS = 8'd2;
  localparam logic [7:0] KIND_AUTOBRIGHT = 8'd3;
  localparam logic [7:0] KIND_ACKALARM   = 8'd4;
  localparam logic [7:0] KIND_DWELL      = 8'd5;
  localparam logic [7:0] KIND_SLEEP      = 8'd6;

  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_THEME      = 3'd1;
  localparam logic [2:0] ACT_SCREEN     = 3'd2;
  localparam logic [2:0] ACT_BRIGHTNESS = 3'd3;
  localparam logic [2:0] ACT_AUTOBRIGHT = 3'd4;
  localparam logic [2:0] ACT_ACKALARM   = 3'd5;
  localparam logic [2:0] ACT_DWELL      = 3'd6;
  localparam logic [2:0] ACT_SLEEP      = 3'd7;

  localparam logic [7:0] THEME_ARG_MAX  = 8'd3;
  localparam logic [7:0] SCREEN_ARG_MAX = 8'd2;
  localparam logic [7:0] BRIGHT_ARG_MAX = 8'd100;
  localparam logic [7:0] SLEEP_ARG_MAX  = 8'd1;
  localparam logic [7:0] DWELL_SHORT    = 8'd3;
  localparam logic [7:0] DWELL_MID      = 8'd6;
  localparam logic [7:0] DWELL_LONG     = 8'd30;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] command_id;
    logic [7:0]  command_kind;
    logic [7:0]  command_arg;
    logic [31:0] time_now_ms;
    logic [63:0] status_bytes;
    logic [31:0] acked_episode;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  action_arg;
    logic        send_report;
    logic [31:0] consumed_id;
  } result_t;

endpackage

// ===== rtl/cdrt_chan_if.sv =====
// cdrt_chan_if: valid/ready channel carrying one payload, a request or a result
// payload type set at instantiation, normally from cdrt_pkg
interface cdrt_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/cdrt_core.sv =====
// cdrt_core: state, configuration registers and per-request decision logic
// command dedup and argument checks, wrap-safe report throttling; uses cdrt_pkg
module cdrt_core
  import cdrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  input  cmd_item_t             item,
  output result_t               result
);

  logic [CFG_DATA_W-1:0] heartbeat;
  logic [CFG_DATA_W-1:0] min_gap;

  logic [31:0] last_consumed_id;
  logic [31:0] reported_id;
  logic [31:0] last_sent_time;
  logic        have_sent;
  logic [63:0] reported_status;
  logic [31:0] reported_episode;

  logic        is_cmd;
  logic        is_poll;
  logic        is_force;
  logic        id_new;
  logic [2:0]  cmd_action;
  logic [7:0]  cmd_arg;
  logic [31:0] age;
  logic        age_neg;
  logic        below_hb;
  logic        at_min;
  logic        changed;
  logic        send;

  assign is_cmd   = (item.opcode == OP_COMMAND);
  assign is_poll  = (item.opcode == OP_POLL);
  assign is_force = (item.opcode == OP_FORCE);
  assign id_new   = (item.command_id > last_consumed_id);

  // kind and argument check
  always_comb begin
    cmd_action = ACT_NONE;
    cmd_arg    = 8'd0;
    case (item.command_kind)
      KIND_THEME: begin
        if (item.command_arg <= THEME_ARG_MAX) begin
          cmd_action = ACT_THEME;
          cmd_arg    = item.command_arg;
        end
      end
      KIND_SCREEN: begin
        if (item.command_arg <= SCREEN_ARG_MAX) begin
          cmd_action = ACT_SCREEN;
          cmd_arg    = item.command_arg;
        end
      end
      KIND_BRIGHTNESS: begin
        if (item.command_arg <= BRIGHT_ARG_MAX) begin
          cmd_action = ACT_BRIGHTNESS;
          cmd_arg    = item.command_arg;
        end
      end
      KIND_AUTOBRIGHT: cmd_action = ACT_AUTOBRIGHT;
      KIND_ACKALARM:   cmd_action = ACT_ACKALARM;
      KIND_DWELL: begin
        if (item.command_arg == DWELL_SHORT || item.command_arg == DWELL_MID ||
            item.command_arg == DWELL_LONG) begin
          cmd_action = ACT_DWELL;
          cmd_arg    = item.command_arg;
        end
      end
      KIND_SLEEP: begin
        if (item.command_arg <= SLEEP_ARG_MAX) begin
          cmd_action = ACT_SLEEP;
          cmd_arg    = item.command_arg;
        end
      end
      default: begin
        cmd_action = ACT_NONE;
        cmd_arg    = 8'd0;
      end
    endcase
  end

  // signed age against the last send time
  assign age      = item.time_now_ms - last_sent_time;
  assign age_neg  = age[31];
  assign below_hb = age_neg || (age[30:0] < heartbeat);
  assign at_min   = !age_neg && (age[30:0] >= min_gap);
  assign changed  = (item.status_bytes != reported_status) ||
                    (item.acked_episode != reported_episode) ||
                    (last_consumed_id != reported_id);
  assign send     = !have_sent || !below_hb || (changed && at_min);

  always_comb begin
    result             = '0;
    result.consumed_id = last_consumed_id;
    if (is_cmd && id_new) begin
      result.action      = cmd_action;
      result.action_arg  = cmd_arg;
      result.consumed_id = item.command_id;
    end
    if (is_poll) begin
      result.send_report = send;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat <= HEARTBEAT_RESET;
      min_gap   <= MIN_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEARTBEAT: heartbeat <= cfg_data;
        CFG_MIN_GAP:   min_gap   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_consumed_id <= '0;
      reported_id      <= '0;
      last_sent_time   <= '0;
      have_sent        <= 1'b0;
      reported_status  <= '0;
      reported_episode <= '0;
    end else if (step) begin
      if (is_cmd && id_new) begin
        last_consumed_id <= item.command_id;
      end
      if (is_poll && send) begin
        reported_status  <= item.status_bytes;
        reported_episode <= item.acked_episode;
        reported_id      <= last_consumed_id;
        last_sent_time   <= item.time_now_ms;
        have_sent        <= 1'b1;
      end
      if (is_force) begin
        have_sent <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/command_dedup_and_report_throttle.sv =====
// command_dedup_and_report_throttle: command dedup and status report throttling
// path: an accepted request goes through the input register and then the result register
// throughput: one request per cycle while results are taken; a waiting result lets one more
// request into the input register and then holds the input
// reset: rst synchronous active high; state cleared, report pending, intervals to defaults
// uses cdrt_pkg, cdrt_chan_if and cdrt_core
module command_dedup_and_report_throttle
  import cdrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cdrt_chan_if.sink             item_in,
  cdrt_chan_if.source           result_out
);

  logic      stage_valid;
  cmd_item_t stage_item;
  logic      res_valid;
  result_t   res_item;
  logic      advance;
  result_t   core_result;

  assign advance       = stage_valid && (!res_valid || result_out.ready);
  assign item_in.ready = !stage_valid || advance;

  cdrt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (stage_item),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_in.ready) begin
      stage_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      stage_item <= item_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || result_out.ready) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= core_result;
    end
  end

  assign result_out.valid = res_valid;
  assign result_out.data  = res_item;

  a_report_no_action: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.send_report |->
      res_item.action == ACT_NONE && res_item.action_arg == 8'd0)
    else $error("report flagged on a request that also carries an action");

  a_arg_needs_action: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.action_arg != 8'd0 |-> res_item.action != ACT_NONE)
    else $error("non-zero argument without an action");

  a_stage_kept: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid)
    else $error("stalled request dropped from the input register");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("processed request did not reach the result register");

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for command_dedup_and_report_throttle
// drives directed and random requests over cdrt_chan_if, predicts or pins each result and checks it
// depends on cdrt_pkg, cdrt_chan_if and the block under test
module tb;
  import cdrt_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 300000;

  typedef struct {
    cmd_item_t it;
    bit        pinned;
    result_t   res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cdrt_chan_if #(.payload_t(cmd_item_t)) item_if ();
  cdrt_chan_if #(.payload_t(result_t))   res_if ();

  command_dedup_and_report_throttle u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (item_if),
    .result_out (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  logic [CFG_DATA_W-1:0] p_heartbeat;
  logic [CFG_DATA_W-1:0] p_min_gap;
  logic [31:0]           p_consumed;
  logic [31:0]           p_rep_id;
  logic [31:0]           p_sent_time;
  logic                  p_have_sent;
  logic [63:0]           p_rep_status;
  logic [31:0]           p_rep_episode;

  // stimulus state
  logic [31:0] sim_now;
  logic [63:0] cur_status;
  logic [31:0] cur_episode;
  int unsigned burst_left = 0;

  result_t  pending_results[$];
  dir_row_t dir_rows[$];
  int       errors = 0;
  int       cycle_count = 0;
  int       n_requests = 0;
  int       n_acted = 0;
  int       n_polls = 0;
  int       n_reports = 0;
  int       n_forces = 0;

  function automatic result_t apply_request(cmd_item_t it);
    result_t     r;
    logic [31:0] age;
    logic        neg;
    logic        below_hb;
    logic        at_min;
    logic        changed;
    r = '0;
    case (it.opcode)
      OP_COMMAND: begin
        if (it.command_id > p_consumed) begin
          p_consumed = it.command_id;
          case (it.command_kind)
            KIND_THEME: if (it.command_arg <= THEME_ARG_MAX) begin
              r.action = ACT_THEME;
              r.action_arg = it.command_arg;
            end
            KIND_SCREEN: if (it.command_arg <= SCREEN_ARG_MAX) begin
              r.action = ACT_SCREEN;
              r.action_arg = it.command_arg;
            end
            KIND_BRIGHTNESS: if (it.command_arg <= BRIGHT_ARG_MAX) begin
              r.action = ACT_BRIGHTNESS;
              r.action_arg = it.command_arg;
            end
            KIND_AUTOBRIGHT: r.action = ACT_AUTOBRIGHT;
            KIND_ACKALARM: r.action = ACT_ACKALARM;
            KIND_DWELL: if (it.command_arg == DWELL_SHORT || it.command_arg == DWELL_MID ||
                            it.command_arg == DWELL_LONG) begin
              r.action = ACT_DWELL;
              r.action_arg = it.command_arg;
            end
            KIND_SLEEP: if (it.command_arg <= SLEEP_ARG_MAX) begin
              r.action = ACT_SLEEP;
              r.action_arg = it.command_arg;
            end
            default: ;
          endcase
        end
      end
      OP_POLL: begin
        // age is signed, a send time in the future is below every threshold
        age = it.time_now_ms - p_sent_time;
        neg = age[31];
        below_hb = neg || (age < {1'b0, p_heartbeat});
        at_min = !neg && (age >= {1'b0, p_min_gap});
        changed = (it.status_bytes != p_rep_status) || (it.acked_episode != p_rep_episode) ||
                  (p_consumed != p_rep_id);
        if (!p_have_sent || !below_hb || (changed && at_min)) begin
          p_rep_status = it.status_bytes;
          p_rep_episode = it.acked_episode;
          p_rep_id = p_consumed;
          p_sent_time = it.time_now_ms;
          p_have_sent = 1'b1;
          r.send_report = 1'b1;
        end
      end
      OP_FORCE: p_have_sent = 1'b0;
      default: ;
    endcase
    r.consumed_id = p_consumed;
    return r;
  endfunction

  function automatic cmd_item_t req(logic [1:0] op, logic [31:0] id, logic [7:0] kind,
                                    logic [7:0] arg, logic [31:0] t, logic [63:0] st,
                                    logic [31:0] ep);
    return {op, id, kind, arg, t, st, ep};
  endfunction

  function automatic result_t res(logic [2:0] act, logic [7:0] arg, logic snd, logic [31:0] id);
    return {act, arg, snd, id};
  endfunction

  function automatic void add_row(cmd_item_t it, bit pinned, result_t r);
    dir_row_t row;
    row.it = it;
    row.pinned = pinned;
    row.res = r;
    dir_rows.push_back(row);
  endfunction

  // random request: well-formed id ascent and moving time, with stale ids and noise
  function automatic cmd_item_t next_request(bit climb);
    cmd_item_t   it;
    int unsigned pick;
    logic [32:0] nid;
    it = {2'd0, $urandom, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(99, 0);
    if (pick < 40) begin
      it.opcode = OP_COMMAND;
      pick = $urandom_range(99, 0);
      if (pick < 75)
        nid = p_consumed + (climb ? $urandom_range(32'h0400_0000, 1) : $urandom_range(3, 1));
      else if (pick < 80)
        nid = p_consumed + $urandom_range(32'h0010_0000, 1);
      else if (pick < 90)
        nid = $urandom_range(p_consumed, 0);
      else if (pick < 95)
        nid = p_consumed;
      else
        nid = '0;
      it.command_id = nid[32] ? 32'hFFFF_FFFF : nid[31:0];
      if ($urandom_range(6, 0) != 0)
        it.command_kind = 8'($urandom_range(6, 0));
      pick = $urandom_range(9, 0);
      if (pick < 5)
        it.command_arg = 8'($urandom_range(7, 0));
      else if (pick < 7)
        case ($urandom_range(4, 0))
          0: it.command_arg = DWELL_SHORT;
          1: it.command_arg = DWELL_MID;
          2: it.command_arg = DWELL_LONG;
          3: it.command_arg = BRIGHT_ARG_MAX;
          default: it.command_arg = BRIGHT_ARG_MAX + 8'd1;
        endcase
    end else if (pick < 88) begin
      it.opcode = OP_POLL;
      pick = $urandom_range(99, 0);
      if (pick < 60)
        sim_now = sim_now + $urandom_range(300, 0);
      else if (pick < 80)
        sim_now = sim_now + $urandom_range(20000, 0);
      else if (pick < 90)
        sim_now = $urandom;
      else
        sim_now = sim_now - $urandom_range(500, 1);
      if ($urandom_range(3, 0) == 0)
        cur_status[8*$urandom_range(7, 0) +: 8] = 8'($urandom);
      if ($urandom_range(15, 0) == 0)
        cur_status = {$urandom, $urandom};
      if ($urandom_range(9, 0) == 0)
        cur_episode = ($urandom_range(3, 0) != 0) ? cur_episode + 1 : $urandom;
      it.time_now_ms = sim_now;
      it.status_bytes = cur_status;
      it.acked_episode = cur_episode;
    end else if (pick < 95) begin
      it.opcode = OP_FORCE;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_request(cmd_item_t it, bit pinned, result_t pin_res);
    result_t r;
    item_if.data <= it;
    item_if.valid <= 1'b1;
    do @(posedge clk); while (!item_if.ready);
    r = apply_request(it);
    pending_results.push_back(pinned ? pin_res : r);
    if (it.opcode != OP_UNUSED)
      n_requests++;
    if (r.action != ACT_NONE)
      n_acted++;
    if (it.opcode == OP_POLL)
      n_polls++;
    if (r.send_report)
      n_reports++;
    if (it.opcode == OP_FORCE)
      n_forces++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(200, 60) : $urandom_range(15, 0);
    end
  endtask

  task automatic drain_requests();
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEARTBEAT)
      p_heartbeat = val;
    else
      p_min_gap = val;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] hb, logic [CFG_DATA_W-1:0] gap, int count,
                           bit climb);
    cmd_item_t it;
    int        done;
    drain_requests();
    write_cfg(CFG_HEARTBEAT, hb);
    write_cfg(CFG_MIN_GAP, gap);
    done = 0;
    while (done < count) begin
      it = next_request(climb);
      send_request(it, 1'b0, '0);
      if (it.opcode != OP_UNUSED)
        done++;
    end
  endtask

  // result side: stall patterns, random hold-offs and one long hold-off
  initial begin
    int unsigned hold;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    int unsigned n_taken;
    bit          long_done;
    hold = 0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    n_taken = 0;
    long_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready)
        n_taken++;
      if (hold == 0 && !long_done && n_taken >= 400) begin
        hold = 200;
        long_done = 1'b1;
      end else if (hold == 0 && $urandom_range(1999, 0) == 0) begin
        hold = $urandom_range(80, 20);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(3, 0);
        mode_left = $urandom_range(128, 16);
      end
      mode_left--;
      tick++;
      if (hold != 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(1, 0));
          2: res_if.ready <= ($urandom_range(3, 0) != 0);
          default: res_if.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 25) begin
            if (got.action !== exp_r.action)
              $display("%0t: action expected %0d got %0d", $time, exp_r.action, got.action);
            if (got.action_arg !== exp_r.action_arg)
              $display("%0t: action_arg expected %0d got %0d", $time, exp_r.action_arg,
                       got.action_arg);
            if (got.send_report !== exp_r.send_report)
              $display("%0t: send_report expected %0b got %0b", $time, exp_r.send_report,
                       got.send_report);
            if (got.consumed_id !== exp_r.consumed_id)
              $display("%0t: consumed_id expected %h got %h", $time, exp_r.consumed_id,
                       got.consumed_id);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HEARTBEAT;
    cfg_data <= '0;
    item_if.valid <= 1'b0;
    item_if.data <= '0;
    p_heartbeat = HEARTBEAT_RESET;
    p_min_gap = MIN_GAP_RESET;
    p_consumed = '0;
    p_rep_id = '0;
    p_sent_time = '0;
    p_have_sent = 1'b0;
    p_rep_status = '0;
    p_rep_episode = '0;

    // first poll after reset always reports
    add_row(req(OP_POLL, 0, 0, 0, 0, 0, 0), 1, res(ACT_NONE, 0, 1, 0));
    add_row(req(OP_POLL, 0, 0, 0, 100, 0, 0), 0, '0);
    // zero id is never consumed
    add_row(req(OP_COMMAND, 0, KIND_THEME, 1, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 0));
    add_row(req(OP_COMMAND, 5, KIND_THEME, 3, 0, 0, 0), 1, res(ACT_THEME, 3, 0, 5));
    add_row(req(OP_COMMAND, 5, KIND_SCREEN, 1, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 5));
    add_row(req(OP_COMMAND, 6, KIND_THEME, 4, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 6));
    add_row(req(OP_COMMAND, 7, KIND_SCREEN, 2, 0, 0, 0), 1, res(ACT_SCREEN, 2, 0, 7));
    add_row(req(OP_COMMAND, 8, KIND_SCREEN, 3, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 8));
    add_row(req(OP_COMMAND, 9, KIND_BRIGHTNESS, 100, 0, 0, 0), 1,
            res(ACT_BRIGHTNESS, 100, 0, 9));
    add_row(req(OP_COMMAND, 10, KIND_BRIGHTNESS, 101, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 10));
    add_row(req(OP_COMMAND, 11, KIND_AUTOBRIGHT, 255, 0, 0, 0), 1,
            res(ACT_AUTOBRIGHT, 0, 0, 11));
    add_row(req(OP_COMMAND, 12, KIND_ACKALARM, 8'hAA, 0, 0, 0), 1, res(ACT_ACKALARM, 0, 0, 12));
    add_row(req(OP_COMMAND, 13, KIND_DWELL, 3, 0, 0, 0), 1, res(ACT_DWELL, 3, 0, 13));
    add_row(req(OP_COMMAND, 14, KIND_DWELL, 30, 0, 0, 0), 1, res(ACT_DWELL, 30, 0, 14));
    add_row(req(OP_COMMAND, 15, KIND_DWELL, 7, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 15));
    add_row(req(OP_COMMAND, 16, KIND_SLEEP, 1, 0, 0, 0), 1, res(ACT_SLEEP, 1, 0, 16));
    add_row(req(OP_COMMAND, 17, KIND_SLEEP, 2, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 17));
    add_row(req(OP_COMMAND, 18, 8'hFF, 0, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 18));
    add_row(req(OP_COMMAND, 3, KIND_DWELL, 6, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 18));
    add_row(req(OP_POLL, 0, 0, 0, 200, '1, '1), 0, '0);
    add_row(req(OP_POLL, 0, 0, 0, 250, '1, '1), 0, '0);
    // send time in the future
    add_row(req(OP_POLL, 0, 0, 0, 32'hFFFF_FFF0, 64'h0123_4567_89AB_CDEF, 0), 0, '0);
    add_row(req(OP_UNUSED, '1, '1, '1, '1, '1, '1), 1, res(ACT_NONE, 0, 0, 18));
    add_row(req(OP_FORCE, 0, 0, 0, 0, 0, 0), 1, res(ACT_NONE, 0, 0, 18));
    add_row(req(OP_POLL, 0, 0, 0, 32'h8000_0000, 0, 0), 1, res(ACT_NONE, 0, 1, 18));
    // heartbeat edge, one below and exactly at
    add_row(req(OP_POLL, 0, 0, 0, 32'h8000_270F, 0, 0), 0, '0);
    add_row(req(OP_POLL, 0, 0, 0, 32'h8000_2710, 0, 0), 0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].res);

    sim_now = 32'h8000_2710;
    cur_status = '0;
    cur_episode = '0;
    run_phase(31'd0, 31'd0, 260, 1'b0);
    run_phase(31'h7FFF_FFFF, 31'h7FFF_FFFF, 260, 1'b0);
    run_phase(31'd1000, 31'd50, 260, 1'b0);
    run_phase(31'h7FFF_FFFF, 31'd0, 260, 1'b0);
    run_phase(31'd20, 31'd5000, 260, 1'b0);
    run_phase(HEARTBEAT_RESET, MIN_GAP_RESET, 260, 1'b0);
    run_phase(31'd300, 31'd100, 265, 1'b1);
    drain_requests();
    repeat (16) @(posedge clk);

    $display("covered %0d requests: %0d commands acted on, %0d polls, %0d reports, %0d forces",
             n_requests, n_acted, n_polls, n_reports, n_forces);
    $display("seven interval settings incl. both extremes, final consumed id %h", p_consumed);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
